// ===== rtl/mvr_pkg.sv =====
// Shared constants and types for the mother-vertex reachability block.
// Used by mvr_cell, mvr_ring and mother_vertex_reachability.
`timescale 1ns / 1ps

package mvr_pkg;

    localparam int KEY_W          = 16;
    localparam int MODE_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int VCOUNT_W       = 6;
    localparam int MAX_VERTICES_DEF = 32;

    localparam logic [MODE_W-1:0] MODE_ADD_VERTEX  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_EDGE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY_VERTEX = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY_GRAPH = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    // Per-cell write strobes.
    typedef struct packed {
        logic add;   // load key, clear adjacency row
        logic link;  // OR the target mask into the row
    } cell_ctl_t;

endpackage

// ===== rtl/mvr_cell.sv =====
// One vertex cell of the ring: a key and its adjacency row.
// Depends on mvr_pkg.
`timescale 1ns / 1ps

module mvr_cell #(
    parameter int N = mvr_pkg::MAX_VERTICES_DEF
) (
    input  logic                     aclk,
    input  logic                     shift_en,
    input  mvr_pkg::cell_ctl_t       ctl,
    input  logic [mvr_pkg::KEY_W-1:0] wr_key,
    input  logic [N-1:0]             tgt_mask,
    input  logic [mvr_pkg::KEY_W-1:0] nbr_key,
    input  logic [N-1:0]             nbr_row,
    output logic [mvr_pkg::KEY_W-1:0] key,
    output logic [N-1:0]             row
);

    logic [mvr_pkg::KEY_W-1:0] key_reg, key_next;
    logic [N-1:0]              row_reg, row_next;

    always_comb begin
        key_next = key_reg;
        row_next = row_reg;
        if (ctl.add) begin
            key_next = wr_key;
            row_next = '0;
        end else if (ctl.link) begin
            row_next = row_reg | tgt_mask;
        end else if (shift_en) begin
            key_next = nbr_key;
            row_next = nbr_row;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        row_reg <= row_next;
    end

    assign key = key_reg;
    assign row = row_reg;

endmodule

// ===== rtl/mvr_ring.sv =====
// Ring of N vertex cells; each shift moves every record one cell toward cell 0.
// Cell 0 is the head seen by the controller. Depends on mvr_pkg, mvr_cell.
`timescale 1ns / 1ps

module mvr_ring #(
    parameter int N = mvr_pkg::MAX_VERTICES_DEF
) (
    input  logic                              aclk,
    input  logic                              shift_en,
    input  mvr_pkg::cell_ctl_t [N-1:0]        cell_ctl,
    input  logic [mvr_pkg::KEY_W-1:0]         wr_key,
    input  logic [N-1:0]                      tgt_mask,
    output logic [mvr_pkg::KEY_W-1:0]         head_key,
    output logic [N-1:0]                      head_row
);

    logic [mvr_pkg::KEY_W-1:0] cell_key [N];
    logic [N-1:0]              cell_row [N];

    for (genvar i = 0; i < N; i++) begin : g_cell
        localparam int NX = (i + 1) % N;
        mvr_cell #(.N(N)) u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .ctl      (cell_ctl[i]),
            .wr_key   (wr_key),
            .tgt_mask (tgt_mask),
            .nbr_key  (cell_key[NX]),
            .nbr_row  (cell_row[NX]),
            .key      (cell_key[i]),
            .row      (cell_row[i])
        );
    end

    assign head_key = cell_key[0];
    assign head_row = cell_row[0];

endmodule

// ===== rtl/mother_vertex_reachability.sv =====
// Mother-vertex reachability block: controller, output register, assertions.
// Depends on mvr_pkg and mvr_ring (which uses mvr_cell).
//
// Usage:
//   Input channel s_* (valid/ready) carries one command per transaction: add
//   vertex, add edge, query one vertex, or query the whole graph. Result
//   channel m_* returns exactly one transaction per command: is_boss, status
//   and the stored vertex count after the command.
//   Commands are handled one at a time. Vertex records sit in a ring of
//   MAX_VERTICES cells that rotates past a single head cell, one record per
//   cycle, so every key lookup and every reachability round costs one full
//   revolution of the ring.
//   Steps per command (C = stored vertices):
//     add vertex / add edge : one lookup revolution, then a write if accepted
//     query vertex          : one lookup revolution, then R search rounds, R =
//                             rounds until the reached set settles, 1 <= R <= C
//     query graph           : R search rounds for each tried start vertex,
//                             stopping at the first boss; none if empty
//   Reset clears the vertex count and all control state; no clearing pass.
//   A new command is taken while the previous result waits in the output
//   register; if the receiver stalls, the finished result of that command
//   waits internally and s_ready stays low until the output register frees.
`timescale 1ns / 1ps

module mother_vertex_reachability #(
    parameter int MAX_VERTICES = mvr_pkg::MAX_VERTICES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [mvr_pkg::MODE_W-1:0]            s_mode,
    input  logic signed [mvr_pkg::KEY_W-1:0]      s_vertex_key,
    input  logic signed [mvr_pkg::KEY_W-1:0]      s_edge_source,
    input  logic signed [mvr_pkg::KEY_W-1:0]      s_edge_target,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_is_boss,
    output logic [mvr_pkg::STATUS_W-1:0]          m_status,
    output logic [mvr_pkg::VCOUNT_W-1:0]          m_vertex_count
);

    localparam int N  = MAX_VERTICES;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK   = 3'd1;
    localparam logic [2:0] S_WRITE  = 3'd2;
    localparam logic [2:0] S_INIT   = 3'd3;
    localparam logic [2:0] S_SEARCH = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]                    state_reg, state_next;
    logic [mvr_pkg::MODE_W-1:0]    mode_reg, mode_next;
    logic [mvr_pkg::KEY_W-1:0]     key_a_reg, key_a_next;
    logic [mvr_pkg::KEY_W-1:0]     key_b_reg, key_b_next;
    logic                          fa_reg, fa_next, fb_reg, fb_next;
    logic [IW-1:0]                 ia_reg, ia_next, ib_reg, ib_next;
    logic [IW-1:0]                 p_reg, p_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 start_reg, start_next;
    logic [N-1:0]                  reached_reg, reached_next;
    logic                          changed_reg, changed_next;
    logic                          boss_reg, boss_next;
    logic [mvr_pkg::STATUS_W-1:0]  status_reg, status_next;

    logic                          m_valid_reg, m_valid_next;
    logic                          m_is_boss_reg, m_is_boss_next;
    logic [mvr_pkg::STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [mvr_pkg::VCOUNT_W-1:0]  m_vertex_count_reg, m_vertex_count_next;

    logic                          shift_en;
    mvr_pkg::cell_ctl_t [N-1:0]    cell_ctl;
    logic [N-1:0]                  tgt_mask;
    logic [N-1:0]                  start_mask;
    logic [N-1:0]                  valid_mask;
    logic [mvr_pkg::KEY_W-1:0]     head_key;
    logic [N-1:0]                  head_row;

    logic                          head_live;
    logic                          pass_end;
    logic                          match_a, match_b;
    logic [N-1:0]                  grow;
    logic                          grew;
    logic                          all_reached;
    logic [CW+mvr_pkg::VCOUNT_W-1:0] count_ext;

    mvr_ring #(.N(N)) u_ring (
        .aclk     (aclk),
        .shift_en (shift_en),
        .cell_ctl (cell_ctl),
        .wr_key   (key_a_reg),
        .tgt_mask (tgt_mask),
        .head_key (head_key),
        .head_row (head_row)
    );

    // Head cell holds vertex p_reg while the ring rotates.
    assign head_live = (CW'(p_reg) < count_reg);
    assign pass_end  = (p_reg == IW'(N - 1));
    assign match_a   = head_live && (head_key == key_a_reg);
    assign match_b   = head_live && (head_key == key_b_reg);
    assign grow      = reached_reg | ((reached_reg[p_reg] && head_live) ? head_row : '0);
    assign grew      = (grow != reached_reg);
    assign all_reached = &(grow | ~valid_mask);
    assign shift_en  = (state_reg == S_LOOK) || (state_reg == S_SEARCH);

    always_comb begin
        for (int i = 0; i < N; i++) begin
            valid_mask[i] = (CW'(i) < count_reg);
            start_mask[i] = (start_reg[IW-1:0] == IW'(i));
            tgt_mask[i]   = (ib_reg == IW'(i));
            cell_ctl[i].add  = (state_reg == S_WRITE) && (mode_reg == mvr_pkg::MODE_ADD_VERTEX)
                               && (count_reg[IW-1:0] == IW'(i));
            cell_ctl[i].link = (state_reg == S_WRITE) && (mode_reg == mvr_pkg::MODE_ADD_EDGE)
                               && (ia_reg == IW'(i));
        end
    end

    assign count_ext = {{mvr_pkg::VCOUNT_W{1'b0}}, count_reg};

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        key_a_next   = key_a_reg;
        key_b_next   = key_b_reg;
        fa_next      = fa_reg;
        fb_next      = fb_reg;
        ia_next      = ia_reg;
        ib_next      = ib_reg;
        p_next       = p_reg;
        count_next   = count_reg;
        start_next   = start_reg;
        reached_next = reached_reg;
        changed_next = changed_reg;
        boss_next    = boss_reg;
        status_next  = status_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_is_boss_next      = m_is_boss_reg;
        m_status_next       = m_status_reg;
        m_vertex_count_next = m_vertex_count_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next   = s_mode;
                    key_a_next  = (s_mode == mvr_pkg::MODE_ADD_EDGE) ? s_edge_source
                                                                     : s_vertex_key;
                    key_b_next  = s_edge_target;
                    fa_next     = 1'b0;
                    fb_next     = 1'b0;
                    p_next      = '0;
                    boss_next   = 1'b0;
                    status_next = mvr_pkg::STATUS_OK;
                    start_next  = '0;
                    if (s_mode != mvr_pkg::MODE_QUERY_GRAPH) begin
                        state_next = S_LOOK;
                    end else if (count_reg == '0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_INIT;
                    end
                end
            end
            S_LOOK: begin
                if (match_a) begin
                    fa_next = 1'b1;
                    ia_next = p_reg;
                end
                if (match_b) begin
                    fb_next = 1'b1;
                    ib_next = p_reg;
                end
                p_next = p_reg + IW'(1);
                if (pass_end) begin
                    p_next = '0;
                    case (mode_reg)
                        mvr_pkg::MODE_ADD_VERTEX: begin
                            if (fa_next) begin
                                status_next = mvr_pkg::STATUS_IGNORED;
                                state_next  = S_DONE;
                            end else if (count_reg == CW'(N)) begin
                                status_next = mvr_pkg::STATUS_FULL;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_WRITE;
                            end
                        end
                        mvr_pkg::MODE_ADD_EDGE: begin
                            if (!fa_next || !fb_next || ia_next == ib_next) begin
                                status_next = mvr_pkg::STATUS_IGNORED;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_WRITE;
                            end
                        end
                        default: begin
                            if (!fa_next) begin
                                status_next = mvr_pkg::STATUS_NOT_FOUND;
                                state_next  = S_DONE;
                            end else begin
                                start_next = CW'(ia_next);
                                state_next = S_INIT;
                            end
                        end
                    endcase
                end
            end
            S_WRITE: begin
                if (mode_reg == mvr_pkg::MODE_ADD_VERTEX) begin
                    count_next = count_reg + CW'(1);
                end
                state_next = S_DONE;
            end
            S_INIT: begin
                reached_next = start_mask;
                changed_next = 1'b0;
                p_next       = '0;
                state_next   = S_SEARCH;
            end
            S_SEARCH: begin
                reached_next = grow;
                changed_next = changed_reg | grew;
                p_next       = p_reg + IW'(1);
                if (pass_end) begin
                    p_next       = '0;
                    changed_next = 1'b0;
                    if (!(changed_reg || grew)) begin
                        if (mode_reg == mvr_pkg::MODE_QUERY_VERTEX) begin
                            boss_next  = all_reached;
                            state_next = S_DONE;
                        end else if (all_reached) begin
                            boss_next  = 1'b1;
                            state_next = S_DONE;
                        end else if (start_reg + CW'(1) == count_reg) begin
                            state_next = S_DONE;
                        end else begin
                            start_next = start_reg + CW'(1);
                            state_next = S_INIT;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_is_boss_next      = boss_reg;
                    m_status_next       = status_reg;
                    m_vertex_count_next = count_ext[mvr_pkg::VCOUNT_W-1:0];
                    state_next          = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg           <= mode_next;
        key_a_reg          <= key_a_next;
        key_b_reg          <= key_b_next;
        fa_reg             <= fa_next;
        fb_reg             <= fb_next;
        ia_reg             <= ia_next;
        ib_reg             <= ib_next;
        p_reg              <= p_next;
        start_reg          <= start_next;
        reached_reg        <= reached_next;
        changed_reg        <= changed_next;
        boss_reg           <= boss_next;
        status_reg         <= status_next;
        m_is_boss_reg      <= m_is_boss_next;
        m_status_reg       <= m_status_next;
        m_vertex_count_reg <= m_vertex_count_next;
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_is_boss      = m_is_boss_reg;
    assign m_status       = m_status_reg;
    assign m_vertex_count = m_vertex_count_reg;

    // Stored count never exceeds the table size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(N))
        else $error("vertex count exceeds table size");

    // A new result appears only when the done state hands it over.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg || m_ready) && state_reg != S_DONE |=> !m_valid_reg)
        else $error("result produced outside done state");

    // Within a round the reached set only grows.
    a_reached_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SEARCH && !pass_end |=>
            (reached_reg & $past(reached_reg)) == $past(reached_reg))
        else $error("reached set lost a vertex");

    // Table-full status only with a full table.
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && status_reg == mvr_pkg::STATUS_FULL |-> count_reg == CW'(N))
        else $error("table full reported with free entries");

endmodule

// ===== bench/mother_vertex_reachability_tb.sv =====
// Self-checking testbench for mother_vertex_reachability: directed and random command
// traffic with a graph predictor and an in-order result scoreboard.
// Depends on mvr_pkg and the mother_vertex_reachability RTL.
`timescale 1ns / 1ps

module mother_vertex_reachability_tb;

    localparam int NV          = mvr_pkg::MAX_VERTICES_DEF;
    localparam int STALL_LIMIT = 200000;
    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic                         is_boss;
        logic [mvr_pkg::STATUS_W-1:0] status;
        logic [mvr_pkg::VCOUNT_W-1:0] vertex_count;
    } graph_result_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic [mvr_pkg::MODE_W-1:0]          s_mode;
    logic signed [mvr_pkg::KEY_W-1:0]    s_vertex_key;
    logic signed [mvr_pkg::KEY_W-1:0]    s_edge_source;
    logic signed [mvr_pkg::KEY_W-1:0]    s_edge_target;
    logic                                m_valid;
    logic                                m_ready;
    logic                                m_is_boss;
    logic [mvr_pkg::STATUS_W-1:0]        m_status;
    logic [mvr_pkg::VCOUNT_W-1:0]        m_vertex_count;

    // predicted graph
    logic [mvr_pkg::KEY_W-1:0] graph_keys [NV];
    logic [NV-1:0]             graph_adj  [NV];
    int                        graph_size;

    graph_result_t expected_results[$];
    int            error_count = 0;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            stall_cycles;

    mother_vertex_reachability dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_vertex_key   (s_vertex_key),
        .s_edge_source  (s_edge_source),
        .s_edge_target  (s_edge_target),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_is_boss      (m_is_boss),
        .m_status       (m_status),
        .m_vertex_count (m_vertex_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [mvr_pkg::KEY_W-1:0] rand_key();
        logic [31:0] bits;
        bits = $urandom;
        return bits[mvr_pkg::KEY_W-1:0];
    endfunction

    function automatic int lookup_key(logic [mvr_pkg::KEY_W-1:0] key);
        for (int i = 0; i < graph_size; i++)
            if (graph_keys[i] == key)
                return i;
        return -1;
    endfunction

    // Grow the reached set round by round until it settles.
    function automatic bit reaches_every_vertex(int start);
        logic [NV-1:0] reached;
        logic [NV-1:0] grown;
        bit            changed;
        reached        = '0;
        reached[start] = 1'b1;
        changed        = 1'b1;
        while (changed) begin
            changed = 1'b0;
            for (int v = 0; v < graph_size; v++) begin
                if (reached[v]) begin
                    grown = reached | graph_adj[v];
                    if (grown != reached) begin
                        reached = grown;
                        changed = 1'b1;
                    end
                end
            end
        end
        for (int v = 0; v < graph_size; v++)
            if (!reached[v])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic graph_result_t apply_command(logic [mvr_pkg::MODE_W-1:0] mode,
                                                    logic [mvr_pkg::KEY_W-1:0] key,
                                                    logic [mvr_pkg::KEY_W-1:0] src,
                                                    logic [mvr_pkg::KEY_W-1:0] dst);
        graph_result_t r;
        int            i;
        int            j;
        logic [31:0]   size_bits;
        r.is_boss = 1'b0;
        r.status  = mvr_pkg::STATUS_OK;
        case (mode)
            mvr_pkg::MODE_ADD_VERTEX: begin
                if (lookup_key(key) >= 0) begin
                    r.status = mvr_pkg::STATUS_IGNORED;
                end else if (graph_size >= NV) begin
                    r.status = mvr_pkg::STATUS_FULL;
                end else begin
                    graph_keys[graph_size] = key;
                    graph_adj[graph_size]  = '0;
                    graph_size++;
                end
            end
            mvr_pkg::MODE_ADD_EDGE: begin
                i = lookup_key(src);
                j = lookup_key(dst);
                if (i < 0 || j < 0 || i == j)
                    r.status = mvr_pkg::STATUS_IGNORED;
                else
                    graph_adj[i][j] = 1'b1;
            end
            mvr_pkg::MODE_QUERY_VERTEX: begin
                i = lookup_key(key);
                if (i < 0)
                    r.status = mvr_pkg::STATUS_NOT_FOUND;
                else
                    r.is_boss = reaches_every_vertex(i);
            end
            default: begin
                for (i = 0; i < graph_size && !r.is_boss; i++)
                    r.is_boss = reaches_every_vertex(i);
            end
        endcase
        size_bits      = graph_size;
        r.vertex_count = size_bits[mvr_pkg::VCOUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (error_count < MAX_REPORTS)
            $display("tb: %0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
        error_count++;
    endtask

    // Valid stays high from one transaction to the next unless an idle cycle is drawn.
    task automatic send_command(logic [mvr_pkg::MODE_W-1:0] mode,
                                logic [mvr_pkg::KEY_W-1:0] key,
                                logic [mvr_pkg::KEY_W-1:0] src,
                                logic [mvr_pkg::KEY_W-1:0] dst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_vertex_key  <= key;
        s_edge_source <= src;
        s_edge_target <= dst;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_results = {expected_results, apply_command(mode, key, src, dst)};
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [mvr_pkg::KEY_W-1:0] pick_stored_key();
        return graph_keys[$urandom_range(graph_size - 1)];
    endfunction

    // noise never adds vertices, so the size caps hold
    function automatic logic [mvr_pkg::MODE_W-1:0] pick_noise_mode();
        logic [31:0] bits;
        bits = $urandom_range(mvr_pkg::MODE_QUERY_GRAPH, mvr_pkg::MODE_ADD_EDGE);
        return bits[mvr_pkg::MODE_W-1:0];
    endfunction

    task automatic test_empty_graph();
        send_command(mvr_pkg::MODE_QUERY_VERTEX, 16'h8000, rand_key(), rand_key());
        send_command(mvr_pkg::MODE_QUERY_GRAPH, rand_key(), rand_key(), rand_key());
        send_command(mvr_pkg::MODE_ADD_EDGE, rand_key(), 16'h7fff, 16'h8000);
    endtask

    task automatic test_add_vertex();
        send_command(mvr_pkg::MODE_ADD_VERTEX, 16'h8000, rand_key(), rand_key());
        send_command(mvr_pkg::MODE_ADD_VERTEX, 16'h7fff, rand_key(), rand_key());
        send_command(mvr_pkg::MODE_ADD_VERTEX, 16'h0000, rand_key(), rand_key());
        send_command(mvr_pkg::MODE_ADD_VERTEX, 16'hffff, rand_key(), rand_key());
        send_command(mvr_pkg::MODE_ADD_VERTEX, 16'h7fff, rand_key(), rand_key());
        // no edges yet, so nobody reaches everyone
        send_command(mvr_pkg::MODE_QUERY_VERTEX, 16'h8000, rand_key(), rand_key());
    endtask

    task automatic test_add_edge();
        send_command(mvr_pkg::MODE_ADD_EDGE, rand_key(), 16'h0000, 16'h0000);
        send_command(mvr_pkg::MODE_ADD_EDGE, rand_key(), 16'h1234, 16'h0000);
        send_command(mvr_pkg::MODE_ADD_EDGE, rand_key(), 16'h0000, 16'h5555);
        // chain against slot order: the search needs one round per hop
        send_command(mvr_pkg::MODE_ADD_EDGE, rand_key(), 16'hffff, 16'h0000);
        send_command(mvr_pkg::MODE_ADD_EDGE, rand_key(), 16'h0000, 16'h7fff);
        send_command(mvr_pkg::MODE_ADD_EDGE, rand_key(), 16'h7fff, 16'h8000);
        send_command(mvr_pkg::MODE_ADD_EDGE, rand_key(), 16'h0000, 16'h7fff);
    endtask

    task automatic test_queries();
        send_command(mvr_pkg::MODE_QUERY_VERTEX, 16'hffff, rand_key(), rand_key());
        send_command(mvr_pkg::MODE_QUERY_VERTEX, 16'h8000, rand_key(), rand_key());
        send_command(mvr_pkg::MODE_QUERY_VERTEX, 16'h4321, rand_key(), rand_key());
        send_command(mvr_pkg::MODE_QUERY_GRAPH, rand_key(), rand_key(), rand_key());
    endtask

    // Mostly lookups and queries on stored keys; the graph grows up to size_cap.
    task automatic test_random_traffic(int items, int size_cap, int send_pct, int recv_pct);
        logic [mvr_pkg::MODE_W-1:0] mode;
        logic [mvr_pkg::KEY_W-1:0]  key;
        logic [mvr_pkg::KEY_W-1:0]  src;
        logic [mvr_pkg::KEY_W-1:0]  dst;
        int                         pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (items) begin
            pick = $urandom_range(99);
            key  = rand_key();
            src  = rand_key();
            dst  = rand_key();
            if (pick < 12) begin
                mode = mvr_pkg::MODE_ADD_VERTEX;
                if (graph_size >= size_cap && graph_size > 0) begin
                    if (graph_size < NV || $urandom_range(1))
                        key = pick_stored_key();
                end
            end else if (pick < 22) begin
                mode = mvr_pkg::MODE_ADD_EDGE;
                if (graph_size > 0 && $urandom_range(99) < 85) begin
                    src = pick_stored_key();
                    dst = pick_stored_key();
                end
            end else if (pick < 72) begin
                mode = mvr_pkg::MODE_QUERY_VERTEX;
                if (graph_size > 0 && $urandom_range(99) < 85)
                    key = pick_stored_key();
            end else if (pick < 77) begin
                mode = mvr_pkg::MODE_QUERY_GRAPH;
            end else begin
                mode = pick_noise_mode();
            end
            send_command(mode, key, src, dst);
        end
    endtask

    always @(posedge aclk) begin : result_check
        graph_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_is_boss !== want.is_boss)
                    report_mismatch("is_boss", int'(m_is_boss), int'(want.is_boss));
                if (m_status !== want.status)
                    report_mismatch("status", int'(m_status), int'(want.status));
                if (m_vertex_count !== want.vertex_count)
                    report_mismatch("vertex_count", int'(m_vertex_count),
                                    int'(want.vertex_count));
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_mode        <= mvr_pkg::MODE_ADD_VERTEX;
        s_vertex_key  <= '0;
        s_edge_source <= '0;
        s_edge_target <= '0;
        graph_size    = 0;
        send_idle_pct = 20;
        recv_idle_pct = 87;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_graph();
        test_add_vertex();
        test_add_edge();
        test_queries();

        test_random_traffic(610, 10, 20, 87);
        pause_until_drained();
        test_random_traffic(610, 20, 87, 20);
        pause_until_drained();
        test_random_traffic(610, NV, 0, 0);

        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (2 * NV) @(posedge aclk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mvr_pkg.sv
rtl/mvr_cell.sv
rtl/mvr_ring.sv
rtl/mother_vertex_reachability.sv
bench/mother_vertex_reachability_tb.sv
